### rtl/obstx_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// obstx_pkg
// Shared codes and types of the oversampled bit-serial transmit/receive block.
// ============================================================================
package obstx_pkg;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_START_TX = 3'd1;
    localparam logic [2:0] OP_START_RX = 3'd2;
    localparam logic [2:0] OP_GO_IDLE  = 3'd3;
    localparam logic [2:0] OP_WRITE    = 3'd4;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_TX   = 2'd1;
    localparam logic [1:0] MODE_RX   = 2'd2;

    localparam logic CFG_OVERSAMPLE_RATE = 1'b0;
    localparam logic CFG_TX_LENGTH       = 1'b1;

    // Where the transmit line level of a result comes from.
    localparam logic [1:0] LINE_KEEP = 2'd0;
    localparam logic [1:0] LINE_ZERO = 2'd1;
    localparam logic [1:0] LINE_RAM  = 2'd2;

    typedef struct packed {
        logic [1:0] line_src;
        logic       tx_done;
        logic       rx_bit_valid;
        logic       rx_bit;
        logic [9:0] rx_bit_index;
        logic       rx_block_done;
        logic [1:0] mode_status;
    } t_stage;

endpackage

### rtl/obstx_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// obstx_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ============================================================================
module obstx_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/obstx_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// obstx_ctrl
// Mode, transmit position and receive vote state; applies one command per
// accepted transfer and issues the transmit store accesses.
// ============================================================================
module obstx_ctrl import obstx_pkg::*; #(
    parameter int BLOCK_BITS = 1024,
    parameter int TX_DEPTH   = 1024,
    parameter int AW         = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [10:0]   i_cfg_data,
    input  logic          i_accept,
    input  logic [2:0]    i_op,
    input  logic          i_rx_level,
    input  logic [9:0]    i_write_index,
    input  logic          i_write_bit,
    output t_stage        o_stage,
    output logic          o_ram_we,
    output logic [AW-1:0] o_ram_waddr,
    output logic          o_ram_wdata,
    output logic          o_ram_re,
    output logic [AW-1:0] o_ram_raddr
);

    localparam int PW = (BLOCK_BITS > 1) ? $clog2(BLOCK_BITS) : 1;
    localparam int XW = (AW > 11) ? AW : 11;
    localparam logic [PW:0] BLOCK_END = (PW + 1)'(BLOCK_BITS);

    logic [7:0]    r_rate;
    logic [10:0]   r_tx_length;
    logic [1:0]    r_mode,     n_mode;
    logic [10:0]   r_tx_pos,   n_tx_pos;
    logic          r_armed,    n_armed;
    logic [7:0]    r_samples,  n_samples;
    logic [7:0]    r_highs,    n_highs;
    logic [PW-1:0] r_rx_pos,   n_rx_pos;

    logic [7:0]    w_rate;
    logic          w_armed;
    logic [8:0]    w_samples;
    logic [8:0]    w_highs;
    logic [PW:0]   w_rx_pos;
    logic [XW-1:0] w_pos_ext;
    logic [XW-1:0] w_widx_ext;

    assign w_rate     = (r_rate == 8'd0) ? 8'd1 : r_rate;
    assign w_pos_ext  = XW'(r_tx_pos);
    assign w_widx_ext = XW'(i_write_index);

    always_comb begin
        n_mode    = r_mode;
        n_tx_pos  = r_tx_pos;
        n_armed   = r_armed;
        n_samples = r_samples;
        n_highs   = r_highs;
        n_rx_pos  = r_rx_pos;
        w_armed   = r_armed | i_rx_level;
        w_samples = {1'b0, r_samples} + 9'd1;
        w_highs   = {1'b0, r_highs} + {8'd0, i_rx_level};
        w_rx_pos  = {1'b0, r_rx_pos};

        o_stage              = '0;
        o_stage.line_src     = LINE_KEEP;
        o_ram_we             = 1'b0;
        o_ram_re             = 1'b0;
        o_ram_waddr          = w_widx_ext[AW-1:0];
        o_ram_wdata          = i_write_bit;
        o_ram_raddr          = w_pos_ext[AW-1:0];

        unique case (i_op)
            OP_TICK: begin
                if (r_mode == MODE_TX) begin
                    if (r_tx_pos < r_tx_length) begin
                        if (32'(r_tx_pos) < TX_DEPTH) begin
                            o_ram_re         = i_accept;
                            o_stage.line_src = LINE_RAM;
                        end else begin
                            o_stage.line_src = LINE_ZERO;
                        end
                        n_tx_pos = r_tx_pos + 11'd1;
                    end else begin
                        n_tx_pos         = '0;
                        n_mode           = MODE_IDLE;
                        o_stage.line_src = LINE_ZERO;
                        o_stage.tx_done  = 1'b1;
                    end
                end else if (r_mode == MODE_RX && w_armed) begin
                    n_armed   = 1'b1;
                    n_samples = w_samples[7:0];
                    n_highs   = w_highs[7:0];
                    if (w_samples >= {1'b0, w_rate}) begin
                        // Majority vote: one when at least half the samples were high.
                        o_stage.rx_bit_valid = 1'b1;
                        o_stage.rx_bit       = ({w_highs, 1'b0} >= {2'b00, w_rate});
                        o_stage.rx_bit_index = 10'(r_rx_pos);
                        w_rx_pos             = {1'b0, r_rx_pos} + (PW + 1)'(1);
                        n_samples            = '0;
                        n_highs              = '0;
                    end
                    if (w_rx_pos >= BLOCK_END) begin
                        n_rx_pos              = '0;
                        n_armed               = 1'b0;
                        o_stage.rx_block_done = 1'b1;
                    end else begin
                        n_rx_pos = w_rx_pos[PW-1:0];
                    end
                end
            end
            OP_START_TX: begin
                if (r_mode == MODE_IDLE) begin
                    n_mode   = MODE_TX;
                    n_tx_pos = '0;
                end
            end
            OP_START_RX: begin
                if (r_mode == MODE_IDLE) begin
                    n_mode    = MODE_RX;
                    n_armed   = 1'b0;
                    n_samples = '0;
                    n_highs   = '0;
                    n_rx_pos  = '0;
                end
            end
            OP_GO_IDLE: begin
                n_mode           = MODE_IDLE;
                n_tx_pos         = '0;
                n_armed          = 1'b0;
                n_samples        = '0;
                n_highs          = '0;
                o_stage.line_src = LINE_ZERO;
            end
            OP_WRITE: begin
                o_ram_we = i_accept && (32'(i_write_index) < TX_DEPTH);
            end
            default: begin
            end
        endcase

        o_stage.mode_status = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= 8'd1;
            r_tx_length <= '0;
            r_mode      <= MODE_IDLE;
            r_tx_pos    <= '0;
            r_armed     <= 1'b0;
            r_samples   <= '0;
            r_highs     <= '0;
            r_rx_pos    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_OVERSAMPLE_RATE: r_rate      <= i_cfg_data[7:0];
                    CFG_TX_LENGTH:       r_tx_length <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_mode    <= n_mode;
                r_tx_pos  <= n_tx_pos;
                r_armed   <= n_armed;
                r_samples <= n_samples;
                r_highs   <= n_highs;
                r_rx_pos  <= n_rx_pos;
            end
        end
    end

endmodule

### rtl/oversampled_bit_serial_txrx_top.sv
`timescale 1ns / 1ps
// ============================================================================
// oversampled_bit_serial_txrx_top
// Tick-driven bit-serial link engine: buffered transmit from a bit store and
// oversampled majority-vote receive.
// ============================================================================
//  Channel   | Handshake                | Payload
//  ----------+--------------------------+---------------------------------------
//  input     | i_in_valid / o_in_stall  | i_op, i_rx_level, i_write_index,
//            |                          | i_write_bit
//  result    | o_out_valid / i_out_stall| o_tx_line, o_tx_done, o_rx_bit_valid,
//            |                          | o_rx_bit, o_rx_bit_index,
//            |                          | o_rx_block_done, o_mode_status
//  config    | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// One transfer is taken every cycle while the input does not stall; each
// result passes the middle stage (with the store read) and output register.
// Synchronous reset clears mode, counters and length and sets rate one; the
// transmit store is not cleared and must be written before it is sent.
// A stall on the result side holds the middle stage, and the input stalls only
// once both the middle stage and the output register are full.
// ============================================================================
module oversampled_bit_serial_txrx_top import obstx_pkg::*; #(
    parameter int BLOCK_BITS = 1024,
    parameter int TX_DEPTH   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic        i_rx_level,
    input  logic [9:0]  i_write_index,
    input  logic        i_write_bit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_tx_line,
    output logic        o_tx_done,
    output logic        o_rx_bit_valid,
    output logic        o_rx_bit,
    output logic [9:0]  o_rx_bit_index,
    output logic        o_rx_block_done,
    output logic [1:0]  o_mode_status
);

    localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    logic          w_accept;
    logic          w_move;
    t_stage        w_stage;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic          w_ram_wdata;
    logic          w_ram_re;
    logic [AW-1:0] w_ram_raddr;
    logic          w_ram_rdata;
    logic          w_line;

    logic          r_mid_valid;
    t_stage        r_mid;
    logic          r_out_valid;
    t_stage        r_out;
    logic          r_out_line;
    logic          r_line_level;

    assign w_move     = r_mid_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_mid_valid && !w_move;
    assign w_accept   = i_in_valid && !o_in_stall;

    obstx_ctrl #(
        .BLOCK_BITS (BLOCK_BITS),
        .TX_DEPTH   (TX_DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (w_accept),
        .i_op          (i_op),
        .i_rx_level    (i_rx_level),
        .i_write_index (i_write_index),
        .i_write_bit   (i_write_bit),
        .o_stage       (w_stage),
        .o_ram_we      (w_ram_we),
        .o_ram_waddr   (w_ram_waddr),
        .o_ram_wdata   (w_ram_wdata),
        .o_ram_re      (w_ram_re),
        .o_ram_raddr   (w_ram_raddr)
    );

    obstx_ram #(
        .WIDTH (1),
        .DEPTH (TX_DEPTH),
        .AW    (AW)
    ) u_tx_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // The read data stays put while the middle stage waits, since no new
    // read is issued until a transfer is taken.
    always_comb begin
        case (r_mid.line_src)
            LINE_RAM:  w_line = w_ram_rdata;
            LINE_ZERO: w_line = 1'b0;
            default:   w_line = r_line_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_line_level <= 1'b0;
        end else begin
            if (w_accept) begin
                r_mid_valid <= 1'b1;
            end else if (w_move) begin
                r_mid_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid  <= 1'b1;
                r_line_level <= w_line;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mid <= w_stage;
        end
        if (w_move) begin
            r_out      <= r_mid;
            r_out_line <= w_line;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tx_line       = r_out_line;
    assign o_tx_done       = r_out.tx_done;
    assign o_rx_bit_valid  = r_out.rx_bit_valid;
    assign o_rx_bit        = r_out.rx_bit;
    assign o_rx_bit_index  = r_out.rx_bit_index;
    assign o_rx_block_done = r_out.rx_block_done;
    assign o_mode_status   = r_out.mode_status;

endmodule

### test/obstx_link_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// obstx_link_checker
// Watches the input, result and register ports of the bit-serial link engine.
// Every accepted input transfer is run through a cycle-free model of the
// engine, and each accepted result is compared field by field with the oldest
// outstanding prediction.
// ============================================================================
module obstx_link_checker import obstx_pkg::*; #(
    parameter int BLOCK_BITS = 1024,
    parameter int TX_DEPTH   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_op,
    input  logic        i_rx_level,
    input  logic [9:0]  i_write_index,
    input  logic        i_write_bit,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_tx_line,
    input  logic        i_tx_done,
    input  logic        i_rx_bit_valid,
    input  logic        i_rx_bit,
    input  logic [9:0]  i_rx_bit_index,
    input  logic        i_rx_block_done,
    input  logic [1:0]  i_mode_status,
    output int          o_expected_count,
    output int          o_error_count
);

    typedef struct packed {
        logic       tx_line;
        logic       tx_done;
        logic       rx_bit_valid;
        logic       rx_bit;
        logic [9:0] rx_bit_index;
        logic       rx_block_done;
        logic [1:0] mode_status;
    } t_link_result;

    // Configuration and state of the engine as seen from outside.
    logic [7:0]  rate_cfg;
    logic [10:0] length_cfg;
    logic [1:0]  link_mode;
    logic [10:0] tx_pos;
    logic        line_level;
    logic        rx_armed;
    logic [7:0]  sample_count;
    logic [7:0]  high_count;
    logic [16:0] rx_pos;
    logic        tx_bits [TX_DEPTH];

    t_link_result expected_results [$];
    t_link_result predicted;
    t_link_result oldest;
    int           errors = 0;
    int           outstanding = 0;

    assign o_expected_count = outstanding;
    assign o_error_count    = errors;

    task automatic clear_receiver();
        rx_armed     = 1'b0;
        sample_count = '0;
        high_count   = '0;
    endtask

    task automatic reset_link();
        rate_cfg   = 8'd1;
        length_cfg = '0;
        link_mode  = MODE_IDLE;
        tx_pos     = '0;
        line_level = 1'b0;
        rx_pos     = '0;
        clear_receiver();
    endtask

    task automatic advance_link(input logic [2:0] code, input logic level,
                                input logic [9:0] index, input logic value,
                                output t_link_result res);
        logic [7:0] eff_rate;
        res = '0;
        case (code)
            OP_TICK: begin
                if (link_mode == MODE_TX) begin
                    if (tx_pos < length_cfg) begin
                        // Positions beyond the store send a low level.
                        line_level = (tx_pos < TX_DEPTH) ? tx_bits[tx_pos] : 1'b0;
                        tx_pos     = tx_pos + 11'd1;
                    end else begin
                        tx_pos      = '0;
                        link_mode   = MODE_IDLE;
                        line_level  = 1'b0;
                        res.tx_done = 1'b1;
                    end
                end else if (link_mode == MODE_RX) begin
                    eff_rate = (rate_cfg == 8'd0) ? 8'd1 : rate_cfg;
                    if (level)
                        rx_armed = 1'b1;
                    if (rx_armed) begin
                        high_count   = high_count + {7'd0, level};
                        sample_count = sample_count + 8'd1;
                        if (sample_count >= eff_rate) begin
                            res.rx_bit_valid = 1'b1;
                            res.rx_bit       = ({high_count, 1'b0} >= {1'b0, eff_rate});
                            res.rx_bit_index = rx_pos[9:0];
                            rx_pos           = rx_pos + 17'd1;
                            sample_count     = '0;
                            high_count       = '0;
                        end
                        if (rx_pos >= BLOCK_BITS) begin
                            rx_pos            = '0;
                            res.rx_block_done = 1'b1;
                            rx_armed          = 1'b0;
                        end
                    end
                end
            end
            OP_START_TX: begin
                if (link_mode == MODE_IDLE) begin
                    link_mode = MODE_TX;
                    tx_pos    = '0;
                end
            end
            OP_START_RX: begin
                if (link_mode == MODE_IDLE) begin
                    link_mode = MODE_RX;
                    clear_receiver();
                    rx_pos = '0;
                end
            end
            OP_GO_IDLE: begin
                link_mode  = MODE_IDLE;
                line_level = 1'b0;
                tx_pos     = '0;
                clear_receiver();
            end
            OP_WRITE: begin
                if (index < TX_DEPTH)
                    tx_bits[index] = value;
            end
            default: begin
            end
        endcase
        res.tx_line     = line_level;
        res.mode_status = link_mode;
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", field, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_link();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_OVERSAMPLE_RATE)
                    rate_cfg = i_cfg_data[7:0];
                else
                    length_cfg = i_cfg_data;
            end
            // Compare before predicting, so a stray result is never matched
            // against the transfer taken at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no prediction outstanding");
                    errors++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("tx_line", oldest.tx_line, i_tx_line);
                    check_field("tx_done", oldest.tx_done, i_tx_done);
                    check_field("rx_bit_valid", oldest.rx_bit_valid, i_rx_bit_valid);
                    check_field("rx_bit", oldest.rx_bit, i_rx_bit);
                    check_field("rx_bit_index", oldest.rx_bit_index, i_rx_bit_index);
                    check_field("rx_block_done", oldest.rx_block_done, i_rx_block_done);
                    check_field("mode_status", oldest.mode_status, i_mode_status);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_link(i_op, i_rx_level, i_write_index, i_write_bit, predicted);
                expected_results.push_back(predicted);
            end
        end
        outstanding = expected_results.size();
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives the bit-serial link engine with directed command sequences, then
// with a complete receive block and extreme settings and finally with
// randomized phases of transmissions, noisy oversampled receptions and stray
// commands, while the sender pauses and the result side stalls at random.
// ============================================================================
module testbench;
    import obstx_pkg::*;

    localparam int BLOCK_BITS  = 1024;
    localparam int TX_DEPTH    = 1024;
    localparam int ITEM_BUDGET = 1450;

    // Op codes that the engine does not define.
    localparam int OP_UNUSED_LO = 5;
    localparam int OP_UNUSED_HI = 7;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [10:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  op;
    logic        rx_level;
    logic [9:0]  write_index;
    logic        write_bit;
    logic        out_valid;
    logic        out_stall;
    logic        tx_line;
    logic        tx_done;
    logic        rx_bit_valid;
    logic        rx_bit;
    logic [9:0]  rx_bit_index;
    logic        rx_block_done;
    logic [1:0]  mode_status;
    int          expected_count;
    int          error_count;

    // Sender bookkeeping.
    bit          store_written [TX_DEPTH];
    int          burst_left = 0;
    int          items_sent = 0;
    logic [7:0]  cur_rate   = 8'd1;
    logic [10:0] cur_length = '0;
    int          stall_tick = 0;

    oversampled_bit_serial_txrx_top #(
        .BLOCK_BITS (BLOCK_BITS),
        .TX_DEPTH   (TX_DEPTH)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_op            (op),
        .i_rx_level      (rx_level),
        .i_write_index   (write_index),
        .i_write_bit     (write_bit),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_tx_line       (tx_line),
        .o_tx_done       (tx_done),
        .o_rx_bit_valid  (rx_bit_valid),
        .o_rx_bit        (rx_bit),
        .o_rx_bit_index  (rx_bit_index),
        .o_rx_block_done (rx_block_done),
        .o_mode_status   (mode_status)
    );

    obstx_link_checker #(
        .BLOCK_BITS (BLOCK_BITS),
        .TX_DEPTH   (TX_DEPTH)
    ) u_link_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_op             (op),
        .i_rx_level       (rx_level),
        .i_write_index    (write_index),
        .i_write_bit      (write_bit),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_tx_line        (tx_line),
        .i_tx_done        (tx_done),
        .i_rx_bit_valid   (rx_bit_valid),
        .i_rx_bit         (rx_bit),
        .i_rx_bit_index   (rx_bit_index),
        .i_rx_block_done  (rx_block_done),
        .i_mode_status    (mode_status),
        .o_expected_count (expected_count),
        .o_error_count    (error_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // The result side switches between stretches of no stalling, sparse and
    // heavy random stalls, and a fixed periodic pattern.
    initial begin : result_stalls
        int style;
        int span;
        out_stall = 1'b0;
        forever begin
            style = $urandom_range(3, 0);
            span  = $urandom_range(80, 8);
            repeat (span) begin
                @(negedge clk);
                stall_tick++;
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(3, 0) == 0);
                    2:       out_stall <= 1'($urandom_range(1, 0));
                    default: out_stall <= ((stall_tick % 5) >= 3);
                endcase
            end
        end
    end

    // Presents one transfer and returns at the falling edge after it is taken.
    task automatic send_item(input logic [2:0] code, input logic level,
                             input logic [9:0] index, input logic value);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(5, 0) == 0) ? $urandom_range(120, 40)
                                                     : $urandom_range(24, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid    <= 1'b1;
        op          <= code;
        rx_level    <= level;
        write_index <= index;
        write_bit   <= value;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        burst_left--;
        items_sent++;
        if (code == OP_WRITE)
            store_written[index] = 1'b1;
    endtask

    task automatic send_cmd(input logic [2:0] code);
        send_item(code, 1'($urandom_range(1, 0)), 10'($urandom_range(1023, 0)),
                  1'($urandom_range(1, 0)));
    endtask

    task automatic send_tick(input logic level);
        send_item(OP_TICK, level, 10'($urandom_range(1023, 0)), 1'($urandom_range(1, 0)));
    endtask

    // Lets the pipeline empty before registers are touched.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_count != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_register(input logic index, input logic [10:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure_link(input logic [7:0] rate, input logic [10:0] tx_len);
        settle();
        write_register(CFG_OVERSAMPLE_RATE, {3'b000, rate});
        write_register(CFG_TX_LENGTH, tx_len);
        cur_rate   = rate;
        cur_length = tx_len;
    endtask

    // Every position a transmission can read must hold a written bit.
    task automatic fill_store();
        for (int i = 0; i < cur_length && i < TX_DEPTH; i++) begin
            if (!store_written[i])
                send_item(OP_WRITE, 1'($urandom_range(1, 0)), 10'(i),
                          1'($urandom_range(1, 0)));
        end
    endtask

    task automatic send_stray();
        int pick;
        logic [2:0] code;
        pick = $urandom_range(4, 0);
        case (pick)
            0: begin
                code = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
                send_cmd(code);
            end
            1: send_cmd(OP_START_RX);
            2: send_cmd(OP_START_TX);
            default: send_cmd(OP_WRITE);
        endcase
    endtask

    task automatic run_transmit(input bit cut_short);
        int ticks;
        ticks = cur_length + 1;
        send_cmd(OP_START_TX);
        for (int n = 0; n < ticks; n++) begin
            if ($urandom_range(9, 0) == 0)
                send_stray();
            if (cut_short && n == ticks / 2)
                send_cmd(OP_GO_IDLE);
            else
                send_tick(1'($urandom_range(1, 0)));
        end
    endtask

    // Sends whole oversampled bits, each sample flipped with a chance that is
    // fixed per reception, so votes land on both sides of the threshold.
    task automatic run_receive(input int bits);
        int eff_rate;
        int flip_pct;
        logic value;
        eff_rate = (cur_rate == 8'd0) ? 1 : cur_rate;
        flip_pct = $urandom_range(40, 0);
        send_cmd(OP_START_RX);
        repeat ($urandom_range(3, 0)) send_tick(1'b0);
        send_tick(1'b1);
        for (int b = 0; b < bits; b++) begin
            value = 1'($urandom_range(1, 0));
            if ($urandom_range(19, 0) == 0)
                send_stray();
            for (int s = 0; s < eff_rate; s++)
                send_tick(($urandom_range(99, 0) < flip_pct) ? ~value : value);
        end
        if ($urandom_range(7, 0) != 0)
            send_cmd(OP_GO_IDLE);
    endtask

    initial begin : stimulus
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_OVERSAMPLE_RATE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        op          = OP_TICK;
        rx_level    = 1'b0;
        write_index = '0;
        write_bit   = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed commands at the reset settings: rate one, zero length.
        send_tick(1'b1);
        for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++)
            send_cmd(3'(c));
        send_item(OP_WRITE, 1'b0, 10'h3FF, 1'b1);
        send_item(OP_WRITE, 1'b1, 10'h000, 1'b1);
        send_cmd(OP_START_TX);
        send_cmd(OP_START_RX);
        send_tick(1'b1);
        send_cmd(OP_START_RX);
        send_cmd(OP_START_TX);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_item(OP_WRITE, 1'b0, 10'h155, 1'b0);
        send_cmd(OP_GO_IDLE);
        send_cmd(OP_GO_IDLE);
        send_tick(1'b0);

        // A transmission cut off by go idle, then a tied vote at rate two.
        configure_link(8'd2, 11'd2);
        fill_store();
        send_cmd(OP_START_TX);
        send_tick(1'b0);
        send_cmd(OP_GO_IDLE);
        send_cmd(OP_START_TX);
        repeat (3) send_tick(1'b1);
        send_cmd(OP_START_RX);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_cmd(OP_GO_IDLE);

        // A complete receive block, after which the bit position wraps.
        configure_link(8'd1, 11'd0);
        run_receive(BLOCK_BITS + 1);
        send_cmd(OP_GO_IDLE);

        // Widest oversampling.
        configure_link(8'd255, 11'd1);
        fill_store();
        run_receive(1);
        run_transmit(1'b0);
        send_cmd(OP_GO_IDLE);

        // A zero rate behaves as one.
        configure_link(8'd0, 11'd5);
        fill_store();
        run_transmit(1'b0);
        run_receive(6);
        send_cmd(OP_GO_IDLE);

        while (items_sent < ITEM_BUDGET) begin
            logic [7:0]  rate;
            logic [10:0] tx_len;
            case ($urandom_range(5, 0))
                0:       rate = 8'd1;
                1:       rate = 8'd2;
                2:       rate = 8'($urandom_range(4, 3));
                3, 4:    rate = 8'($urandom_range(9, 5));
                default: rate = 8'($urandom_range(24, 10));
            endcase
            tx_len = 11'(($urandom_range(3, 0) == 0) ? $urandom_range(120, 25)
                                                     : $urandom_range(24, 0));
            configure_link(rate, tx_len);
            fill_store();
            repeat ($urandom_range(6, 2)) begin
                case ($urandom_range(9, 0))
                    0, 1, 2, 3: run_transmit(1'b0);
                    4, 5, 6, 7: run_receive($urandom_range(12, 1));
                    8:          run_transmit(1'b1);
                    default:    repeat ($urandom_range(6, 1)) send_stray();
                endcase
            end
            send_cmd(OP_GO_IDLE);
        end

        settle();
        repeat (8) @(negedge clk);
        if (error_count == 0 && expected_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/obstx_pkg.sv
rtl/obstx_ram.sv
rtl/obstx_ctrl.sv
rtl/oversampled_bit_serial_txrx_top.sv
test/obstx_link_checker.sv
test/testbench.sv
